// File: rtl/core/i104_pkg.sv
// ----------------------------------------------------------------------------
// i104_pkg
// Shared types and constants of the IEC 104 master link controller.
// ----------------------------------------------------------------------------
package i104_pkg;

  localparam int unsigned SEQ_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [1:0] MODE_FRAME = 2'd0;
  localparam logic [1:0] MODE_SLOT  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_START = 2'd3;

  localparam logic [1:0] KIND_I = 2'd0;
  localparam logic [1:0] KIND_S = 2'd1;
  localparam logic [1:0] KIND_U = 2'd2;

  localparam logic [7:0] U_STARTDT_ACT = 8'h07;
  localparam logic [7:0] U_STARTDT_CON = 8'h0b;
  localparam logic [7:0] U_TESTFR_ACT  = 8'h43;
  localparam logic [7:0] U_TESTFR_CON  = 8'h83;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SEND_U   = 3'd1;
  localparam logic [2:0] ACT_SEND_S   = 3'd2;
  localparam logic [2:0] ACT_SEND_I   = 3'd3;
  localparam logic [2:0] ACT_DROP     = 3'd4;
  localparam logic [2:0] ACT_INTERROG = 3'd5;

  localparam logic [3:0] RETRY_LIMIT  = 4'd10;
  localparam logic [7:0] MAX_ASDU_LEN = 8'd249;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TMO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_TMO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_MAX      = 3'd4;

  localparam logic [7:0]       RST_ACK_TMO  = 8'd10;
  localparam logic [7:0]       RST_TEST_TMO = 8'd20;
  localparam logic [SEQ_W-1:0] RST_K_MAX    = 15'd12;
  localparam logic [7:0]       RST_W_MAX    = 8'd8;

  typedef enum logic [5:0] {
    ST_INIT        = 6'b000001,
    ST_NODATA      = 6'b000010,
    ST_NORMAL      = 6'b000100,
    ST_TESTACT     = 6'b001000,
    ST_TESTCONFIRM = 6'b010000,
    ST_CALLALL     = 6'b100000
  } link_state_t;

  typedef struct packed {
    logic             run_enable;
    logic [7:0]       ack_timeout_s;
    logic [7:0]       test_timeout_s;
    logic [SEQ_W-1:0] k_window_max;
    logic [7:0]       w_window_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [1:0]       frame_kind;
    logic [7:0]       u_code;
    logic [SEQ_W-1:0] peer_send_no;
    logic [SEQ_W-1:0] peer_recv_no;
    logic             queue_has_data;
    logic [7:0]       head_length;
  } item_t;

endpackage

// File: rtl/core/i104_cfg_regs.sv
// ----------------------------------------------------------------------------
// i104_cfg_regs
// Configuration register file written over the cfg request channel.
// ----------------------------------------------------------------------------
module i104_cfg_regs
  import i104_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_RUN_ENABLE: cfg_nxt.run_enable     = cfg_data[0];
        REG_ACK_TMO:    cfg_nxt.ack_timeout_s  = cfg_data[7:0];
        REG_TEST_TMO:   cfg_nxt.test_timeout_s = cfg_data[7:0];
        REG_K_MAX:      cfg_nxt.k_window_max   = cfg_data[SEQ_W-1:0];
        REG_W_MAX:      cfg_nxt.w_window_max   = cfg_data[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_enable     <= 1'b0;
      cfg_r.ack_timeout_s  <= RST_ACK_TMO;
      cfg_r.test_timeout_s <= RST_TEST_TMO;
      cfg_r.k_window_max   <= RST_K_MAX;
      cfg_r.w_window_max   <= RST_W_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/i104_in_reg.sv
// ----------------------------------------------------------------------------
// i104_in_reg
// Input register: unpacks and holds one request until the core takes it.
// ----------------------------------------------------------------------------
module i104_in_reg
  import i104_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  input  logic                 take,
  output logic                 item_valid,
  output item_t                item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_in;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_in.mode           = in_tuser[1:0];
    item_in.frame_kind     = in_tuser[3:2];
    item_in.u_code         = in_tdata[7:0];
    item_in.peer_send_no   = in_tdata[22:8];
    item_in.peer_recv_no   = in_tdata[37:23];
    item_in.queue_has_data = in_tdata[38];
    item_in.head_length    = in_tdata[46:39];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_in;
    end
  end

endmodule

// File: rtl/core/i104_link_ctrl.sv
// ----------------------------------------------------------------------------
// i104_link_ctrl
// Link state, sequence counters and timers; one action per request into the
// result register.
// ----------------------------------------------------------------------------
module i104_link_ctrl
  import i104_pkg::*;
#(
  parameter int unsigned SEQ_BITS = 15
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  item_valid,
  input  item_t                 item,
  output logic                  take,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  link_state_t         state_r,      state_nxt;
  logic [SEQ_BITS-1:0] own_send_r,   own_send_nxt;
  logic [SEQ_BITS-1:0] own_recv_r,   own_recv_nxt;
  logic [SEQ_BITS-1:0] unacked_r,    unacked_nxt;
  logic [7:0]          unconf_r,     unconf_nxt;
  logic [7:0]          idle_r,       idle_nxt;
  logic                ack_pend_r,   ack_pend_nxt;
  logic [3:0]          retry_r,      retry_nxt;

  logic                out_valid_r;
  logic [2:0]          out_action_r, action_nxt;
  logic [7:0]          out_ucode_r,  ucode_nxt;
  logic [SEQ_W-1:0]    out_send_r,   send_out_nxt;
  logic [SEQ_W-1:0]    out_recv_r,   recv_out_nxt;

  logic [SEQ_BITS-1:0] peer_ns;
  logic [SEQ_BITS-1:0] peer_nr;
  logic [SEQ_BITS-1:0] k_from_peer;
  logic [7:0]          unconf_inc;
  logic [3:0]          retry_inc;
  logic                ack_due;
  logic                can_send;
  logic                bad_len;

  assign take       = item_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = {2'b00, out_recv_r, out_send_r, out_ucode_r};

  assign peer_ns     = item.peer_send_no[SEQ_BITS-1:0];
  assign peer_nr     = item.peer_recv_no[SEQ_BITS-1:0];
  assign k_from_peer = own_send_r - peer_nr;
  assign unconf_inc  = (unconf_r == 8'hff) ? unconf_r : unconf_r + 8'd1;
  assign retry_inc   = retry_r + 4'd1;
  assign ack_due     = (state_r == ST_NORMAL) ||
                       (ack_pend_r && (idle_r > cfg.ack_timeout_s));
  assign can_send    = item.queue_has_data &&
                       (SEQ_W'(unacked_r) < cfg.k_window_max);
  assign bad_len     = (item.head_length == 8'd0) || (item.head_length > MAX_ASDU_LEN);

  always_comb begin
    state_nxt    = state_r;
    own_send_nxt = own_send_r;
    own_recv_nxt = own_recv_r;
    unacked_nxt  = unacked_r;
    unconf_nxt   = unconf_r;
    idle_nxt     = idle_r;
    ack_pend_nxt = ack_pend_r;
    retry_nxt    = retry_r;
    action_nxt   = ACT_NONE;
    ucode_nxt    = 8'd0;
    send_out_nxt = '0;
    recv_out_nxt = '0;
    if (cfg.run_enable) begin
      case (item.mode)
        MODE_FRAME: begin
          if (item.frame_kind == KIND_I || item.frame_kind == KIND_S ||
              item.frame_kind == KIND_U) begin
            idle_nxt = 8'd0;
          end
          case (item.frame_kind)
            KIND_U: begin
              if (item.u_code == U_STARTDT_CON) begin
                action_nxt = ACT_INTERROG;
                state_nxt  = ST_CALLALL;
              end else if (item.u_code == U_TESTFR_ACT) begin
                state_nxt = ST_TESTCONFIRM;
              end else if (item.u_code == U_TESTFR_CON) begin
                state_nxt = ST_NODATA;
              end
            end
            KIND_S: begin
              unacked_nxt = k_from_peer;
            end
            KIND_I: begin
              own_recv_nxt = peer_ns + SEQ_BITS'(1);
              unconf_nxt   = unconf_inc;
              unacked_nxt  = k_from_peer;
              ack_pend_nxt = 1'b1;
              state_nxt    = (unconf_inc >= cfg.w_window_max) ? ST_NORMAL : ST_NODATA;
            end
            default: begin
            end
          endcase
        end
        MODE_SLOT: begin
          if (state_r == ST_INIT) begin
            retry_nxt = retry_inc;
            if (retry_inc > RETRY_LIMIT) begin
              retry_nxt  = 4'd0;
              action_nxt = ACT_SEND_U;
              ucode_nxt  = U_STARTDT_ACT;
              state_nxt  = ST_NODATA;
            end
          end else if (ack_due) begin
            action_nxt   = ACT_SEND_S;
            recv_out_nxt = SEQ_W'(own_recv_r);
            unconf_nxt   = 8'd0;
            ack_pend_nxt = 1'b0;
            state_nxt    = ST_NODATA;
          end else if (state_r == ST_TESTACT) begin
            action_nxt = ACT_SEND_U;
            ucode_nxt  = U_TESTFR_ACT;
            state_nxt  = ST_NODATA;
          end else if (state_r == ST_TESTCONFIRM) begin
            action_nxt = ACT_SEND_U;
            ucode_nxt  = U_TESTFR_CON;
            state_nxt  = ST_NODATA;
          end else if (can_send) begin
            if (bad_len) begin
              action_nxt = ACT_DROP;
            end else begin
              action_nxt   = ACT_SEND_I;
              send_out_nxt = SEQ_W'(own_send_r);
              recv_out_nxt = SEQ_W'(own_recv_r);
              unacked_nxt  = unacked_r + SEQ_BITS'(1);
              own_send_nxt = own_send_r + SEQ_BITS'(1);
              unconf_nxt   = 8'd0;
            end
          end else if (idle_r > cfg.test_timeout_s) begin
            state_nxt = ST_TESTACT;
            idle_nxt  = 8'd0;
          end
        end
        MODE_TICK: begin
          if (idle_r != 8'hff) begin
            idle_nxt = idle_r + 8'd1;
          end
        end
        MODE_START: begin
          state_nxt    = ST_INIT;
          own_send_nxt = '0;
          own_recv_nxt = '0;
          unacked_nxt  = '0;
          unconf_nxt   = 8'd0;
          idle_nxt     = 8'd0;
          ack_pend_nxt = 1'b0;
          retry_nxt    = 4'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      own_send_r  <= '0;
      own_recv_r  <= '0;
      unacked_r   <= '0;
      unconf_r    <= 8'd0;
      idle_r      <= 8'd0;
      ack_pend_r  <= 1'b0;
      retry_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r    <= state_nxt;
        own_send_r <= own_send_nxt;
        own_recv_r <= own_recv_nxt;
        unacked_r  <= unacked_nxt;
        unconf_r   <= unconf_nxt;
        idle_r     <= idle_nxt;
        ack_pend_r <= ack_pend_nxt;
        retry_r    <= retry_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_action_r <= action_nxt;
      out_ucode_r  <= ucode_nxt;
      out_send_r   <= send_out_nxt;
      out_recv_r   <= recv_out_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r <= RETRY_LIMIT)
    else $error("start retry counter passed its limit");

  a_ucode_only_u: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != ACT_SEND_U) |-> (out_ucode_r == 8'd0))
    else $error("U code on a non-U action");

  a_send_only_i: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != ACT_SEND_I) |-> (out_send_r == '0))
    else $error("send number on a non-I action");

  a_halted_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !cfg.run_enable) |=> ($stable(state_r) && $stable(own_send_r) &&
                                   $stable(idle_r) && out_action_r == ACT_NONE))
    else $error("state moved while not running");
`endif

endmodule

// File: rtl/core/iec104_master_link_control.sv
// An accepted request is held in the input register, then its action is
// written into the result register. Throughput: one request per cycle
// unless out_tready stalls the result register; the state update is a single
// pass of compares and increments between the input and result registers.
// Reset (rst_n low, synchronous) returns the link to INIT with all counters
// cleared, the configuration registers to their defaults and both channels
// to empty.
// ----------------------------------------------------------------------------
// iec104_master_link_control
// Master-side IEC 104 APCI link controller: one action per request.
// ----------------------------------------------------------------------------
module iec104_master_link_control
  import i104_pkg::*;
#(
  parameter int unsigned SEQ_BITS = 15
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] u_code, [22:8] peer_send_no, [37:23] peer_recv_no,
  // [38] queue_has_data, [46:39] head_length, [47] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode, [3:2] frame_kind
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] u_code_out, [22:8] send_no_out, [37:23] recv_no_out, [39:38] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] action
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  i104_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i104_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  i104_link_ctrl #(
    .SEQ_BITS (SEQ_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
